// ----- design/ple_pkg.sv -----
// ----------------------------------------------------------------------------
// ple_pkg
// Shared widths, operation and status codes, and the cell command type
// for the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int KIND_W           = 4;
  localparam int VALUE_W          = 32;
  localparam int POS_W            = 5;
  localparam int STATUS_W         = 2;
  localparam int COUNT_W          = 5;
  localparam int DEFAULT_CAPACITY = 16;

  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 4'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 4'd1;
  localparam logic [KIND_W-1:0] KIND_INSERT     = 4'd2;
  localparam logic [KIND_W-1:0] KIND_DELETE     = 4'd3;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 4'd4;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 4'd5;
  localparam logic [KIND_W-1:0] KIND_GET        = 4'd6;
  localparam logic [KIND_W-1:0] KIND_FRONT      = 4'd7;
  localparam logic [KIND_W-1:0] KIND_BACK       = 4'd8;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BOUNDS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

  // shift command broadcast to every cell of the row
  typedef struct packed {
    logic ins;  // open a gap at the target and write the new value there
    logic del;  // close the gap at the target
  } shift_cmd_t;

endpackage

// ----- design/ple_cell.sv -----
// ----------------------------------------------------------------------------
// ple_cell
// One storage cell of the list row. Holds one entry and takes the value of
// its left or right neighbor when the row shifts, or the new value at the target.
// ----------------------------------------------------------------------------
module ple_cell #(
  parameter int ID    = 0,
  parameter int CMP_W = 5
) (
  input  logic                             clk,
  input  ple_pkg::shift_cmd_t              cmd,
  input  logic [CMP_W-1:0]                 target,
  input  logic signed [ple_pkg::VALUE_W-1:0] new_value,
  input  logic signed [ple_pkg::VALUE_W-1:0] left_value,
  input  logic signed [ple_pkg::VALUE_W-1:0] right_value,
  output logic signed [ple_pkg::VALUE_W-1:0] value
);
  import ple_pkg::*;

  localparam logic [CMP_W-1:0] MY_ID = CMP_W'(ID);

  logic signed [VALUE_W-1:0] value_next;

  always_comb begin
    value_next = value;
    if (cmd.ins) begin
      if (MY_ID > target) begin
        value_next = left_value;
      end else if (MY_ID == target) begin
        value_next = new_value;
      end
    end else if (cmd.del) begin
      if (MY_ID >= target) begin
        value_next = right_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

// ----- design/positional_list_engine.sv -----
// ----------------------------------------------------------------------------
// positional_list_engine
// Bounded ordered list of signed 32-bit values held in a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one operation per transfer:
//   kind, item_value and position. Output channel (out_valid / out_stall)
//   returns exactly one result per operation: read_value, status,
//   entry_count and is_empty.
//   The result of an accepted operation is registered and is shown on
//   the output from the next cycle on.
//   Throughput is one operation per cycle while no result waits under
//   out_stall. Inserts and deletes shift every cell of the row in the
//   same cycle, so each operation sees the list as the one before left it.
//   The single output register is the only buffer: while a result waits
//   under out_stall, in_stall is raised and the result holds unchanged.
//   Reset empties the list and drops any pending result; the stored values
//   are not cleared, as no entry at or beyond the count is ever returned.
// ----------------------------------------------------------------------------
module positional_list_engine #(
  parameter int CAPACITY = ple_pkg::DEFAULT_CAPACITY
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [ple_pkg::KIND_W-1:0]         kind,
  input  logic signed [ple_pkg::VALUE_W-1:0] item_value,
  input  logic [ple_pkg::POS_W-1:0]          position,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [ple_pkg::VALUE_W-1:0] read_value,
  output logic [ple_pkg::STATUS_W-1:0]       status,
  output logic [ple_pkg::COUNT_W-1:0]        entry_count,
  output logic                               is_empty
);
  import ple_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

  logic signed [VALUE_W-1:0] cell_q [CAPACITY];

  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [CMP_W-1:0]   count_x;
  logic [CMP_W-1:0]   pos_x;
  logic [CMP_W-1:0]   target;
  logic [CMP_W-1:0]   rd_addr;
  logic               accept;
  logic               do_ins;
  logic               do_del;
  logic               rd_hit;
  logic               rd_neg;
  logic [STATUS_W-1:0] st;
  logic signed [VALUE_W-1:0] rd_cell;
  logic signed [VALUE_W-1:0] rd_result;
  shift_cmd_t         cmd;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign count_x  = CMP_W'(count);
  assign pos_x    = CMP_W'(position);

  always_comb begin
    do_ins  = 1'b0;
    do_del  = 1'b0;
    rd_hit  = 1'b0;
    rd_neg  = 1'b0;
    st      = ST_OK;
    target  = pos_x;
    rd_addr = '0;
    unique case (kind)
      KIND_PUSH_BACK, KIND_PUSH_FRONT, KIND_INSERT: begin
        if (kind == KIND_PUSH_BACK) begin
          target = count_x;
        end else if (kind == KIND_PUSH_FRONT) begin
          target = '0;
        end
        if (count == FULL_COUNT) begin
          st = ST_FULL;
        end else if (target > count_x) begin
          st = ST_BOUNDS;
        end else begin
          do_ins = 1'b1;
        end
      end
      KIND_DELETE, KIND_POP_BACK, KIND_POP_FRONT: begin
        if (kind == KIND_POP_BACK) begin
          target = count_x - CMP_W'(1);
        end else if (kind == KIND_POP_FRONT) begin
          target = '0;
        end
        if (count == '0) begin
          st = ST_EMPTY;
        end else if (target >= count_x) begin
          st = ST_BOUNDS;
        end else begin
          do_del = 1'b1;
        end
      end
      KIND_GET: begin
        rd_addr = pos_x;
        if (count == '0) begin
          st = ST_EMPTY;
        end else if (pos_x >= count_x) begin
          st = ST_BOUNDS;
        end else begin
          rd_hit = 1'b1;
        end
      end
      KIND_FRONT, KIND_BACK: begin
        rd_addr = (kind == KIND_BACK) ? count_x - CMP_W'(1) : '0;
        if (count == '0) begin
          st     = ST_EMPTY;
          rd_neg = 1'b1;
        end else begin
          rd_hit = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // single read port into the row; only addresses below the count are used
  assign rd_cell   = cell_q[rd_addr[IDX_W-1:0]];
  assign rd_result = rd_neg ? -32'sd1 : (rd_hit ? rd_cell : '0);

  always_comb begin
    count_next = count;
    if (do_ins) begin
      count_next = count + CNT_W'(1);
    end else if (do_del) begin
      count_next = count - CNT_W'(1);
    end
  end

  assign cmd.ins = accept & do_ins;
  assign cmd.del = accept & do_del;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_W-1:0] left_v;
    logic signed [VALUE_W-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = item_value;
    end else begin : g_mid_l
      assign left_v = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = cell_q[i];
    end else begin : g_mid_r
      assign right_v = cell_q[i+1];
    end
    ple_cell #(
      .ID    (i),
      .CMP_W (CMP_W)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .target      (target),
      .new_value   (item_value),
      .left_value  (left_v),
      .right_value (right_v),
      .value       (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, loaded on every input transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      read_value  <= rd_result;
      status      <= st;
      entry_count <= COUNT_W'(count_next);
      is_empty    <= (count_next == '0);
    end
  end

endmodule

// ----- design/ple_checker.sv -----
// ----------------------------------------------------------------------------
// ple_checker
// Port-level checks for the positional list engine, bound to the top level.
// ----------------------------------------------------------------------------
module ple_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [ple_pkg::VALUE_W-1:0] read_value,
  input logic [ple_pkg::STATUS_W-1:0]       status,
  input logic                               is_empty
);
  import ple_pkg::*;

  // every input transfer shows its result on the next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("result missing one cycle after input transfer");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(read_value) && $stable(status)))
    else $error("stalled result changed");

  // out-of-bounds accesses and writes refused as full read zero
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_BOUNDS || status == ST_FULL)) |-> (read_value == '0))
    else $error("nonzero read value on bounds or full status");

  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_empty) |-> (status != ST_FULL))
    else $error("full status reported with an empty list");

endmodule

bind positional_list_engine ple_checker u_ple_checker (.*);
